// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the flash write sequencer RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside of reset.
`define ASSERT_IMPLIES(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("assertion failed");

// Implication whose consequence is checked at the following clock edge.
`define ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("assertion failed");

`endif

// ===== rtl/core/fwseq_pkg.sv =====
// Package of the flash write sequencer: codes, widths, queue entry and state types.
// No dependencies; used by every module of the block.
package fwseq_pkg;

   localparam int DEF_COMMAND_SLOTS = 16;
   localparam int QUEUE_DEPTH       = 2;
   localparam int CSR_INDEX_W       = 4;

   localparam logic [23:0] ADDR_ALL_ONES = 24'hFFFFFF;

   localparam logic [2:0] FUNC_HOLD        = 3'd0;
   localparam logic [2:0] FUNC_RUN         = 3'd1;
   localparam logic [2:0] FUNC_INIT        = 3'd2;
   localparam logic [2:0] FUNC_START_READ  = 3'd3;
   localparam logic [2:0] FUNC_START_WRITE = 3'd4;
   localparam logic [2:0] FUNC_READ_BYTE   = 3'd5;
   localparam logic [2:0] FUNC_WRITE_BYTE  = 3'd6;

   localparam logic [CSR_INDEX_W-1:0] CSR_BLOCK_SIZE = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MUX_MODE   = 4'd1;

   localparam logic ACCESS_WRITE = 1'b0;
   localparam logic ACCESS_READ  = 1'b1;
   localparam logic SOURCE_TABLE = 1'b0;
   localparam logic SOURCE_DATA  = 1'b1;

   typedef enum logic [2:0] {
      OP_HOLD,
      OP_RUN,
      OP_INIT,
      OP_START_READ,
      OP_START_WRITE,
      OP_READ_BYTE,
      OP_WRITE_BYTE
   } op_type;

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_READ,
      MODE_WRITE
   } mode_type;

   typedef enum logic [1:0] {
      B_IDLE,
      B_REPLAY,
      B_DATA
   } back_state_type;

   typedef struct packed {
      op_type      op;
      logic [23:0] cmd_address;
      logic [7:0]  cmd_data;
      logic [31:0] start_address;
      logic [15:0] write_length;
      logic [7:0]  data_byte;
   } entry_type;

   typedef struct packed {
      logic not_empty;
      logic full;
   } q_status_type;

endpackage

// ===== rtl/core/flash_write_sequencer_with_unlock_table.sv =====
// Top level of the flash write sequencer with its stored unlock-command table.
// Depends on fwseq_pkg, assert_macros.svh, fwseq_front, fwseq_queue and fwseq_back.
//
// Usage: request transactions (req_*) carry one command or data item each; a
// transaction is taken when req_valid is high and req_stall is low. Every flash
// access comes out as one response transaction (rsp_*), taken when rsp_valid is
// high and rsp_stall is low; rsp_last marks the final access of one request.
// The csr_* port writes block_size (index 0) and mux_mode (index 1) and is
// always ready; the user must write it only while the block has no work in
// flight, and the block itself does not enforce this. A request enters the
// two-entry queue and is popped by the back end, only when idle; its accesses
// leave through the output register. An item that emits nothing ends there; a
// read or write byte goes through the data state, a write byte first replaying
// the N stored commands (up to 16) when a replay is due, as a run item does.
// The single table read port, stepping one entry per cycle while the output
// register is free, sets the replay rate. Reset clears the queue, the table
// fill count, address, countdown, mode and registers; no clearing pass is
// needed. While the receiver stalls, the held response stays put, the back
// end waits, and the queue fills before req_stall is raised toward the sender.
module flash_write_sequencer_with_unlock_table #(
   parameter int COMMAND_SLOTS = fwseq_pkg::DEF_COMMAND_SLOTS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [2:0]                        req_func,
   input  logic [23:0]                       req_cmd_address,
   input  logic [7:0]                        req_cmd_data,
   input  logic [31:0]                       req_start_address,
   input  logic [15:0]                       req_write_length,
   input  logic [7:0]                        req_data_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_access_kind,
   output logic                              rsp_access_source,
   output logic [31:0]                       rsp_flash_address,
   output logic [7:0]                        rsp_write_value,
   output logic [7:0]                        rsp_latch_low,
   output logic [7:0]                        rsp_latch_mid,
   output logic [7:0]                        rsp_latch_high,
   output logic [7:0]                        rsp_column_low,
   output logic [7:0]                        rsp_column_high,
   output logic                              rsp_last,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [fwseq_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]                       csr_data
);

`include "assert_macros.svh"

   fwseq_pkg::q_status_type q_status;
   fwseq_pkg::entry_type    push_entry;
   fwseq_pkg::entry_type    head_entry;
   logic                    q_push;
   logic                    q_pop;

   // The register file accepts a write in any cycle.
   assign csr_ready = 1'b1;

   fwseq_front u_front (
      .req_valid         (req_valid),
      .req_func          (req_func),
      .req_cmd_address   (req_cmd_address),
      .req_cmd_data      (req_cmd_data),
      .req_start_address (req_start_address),
      .req_write_length  (req_write_length),
      .req_data_byte     (req_data_byte),
      .req_stall         (req_stall),
      .q_status          (q_status),
      .q_push            (q_push),
      .q_entry           (push_entry)
   );

   fwseq_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .pop        (q_pop),
      .head_entry (head_entry),
      .status     (q_status)
   );

   fwseq_back #(
      .COMMAND_SLOTS (COMMAND_SLOTS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_status          (q_status),
      .q_entry           (head_entry),
      .q_pop             (q_pop),
      .csr_valid         (csr_valid && csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_access_kind   (rsp_access_kind),
      .rsp_access_source (rsp_access_source),
      .rsp_flash_address (rsp_flash_address),
      .rsp_write_value   (rsp_write_value),
      .rsp_latch_low     (rsp_latch_low),
      .rsp_latch_mid     (rsp_latch_mid),
      .rsp_latch_high    (rsp_latch_high),
      .rsp_column_low    (rsp_column_low),
      .rsp_column_high   (rsp_column_high),
      .rsp_last          (rsp_last)
   );

   // A read access is always a lone stream access with a zero data byte.
   `ASSERT_IMPLIES(a_read_is_lone, clock, reset, rsp_valid && rsp_access_kind, rsp_access_source && (rsp_write_value == 8'h00) && rsp_last)
   // Replayed table commands are always writes.
   `ASSERT_IMPLIES(a_table_is_write, clock, reset, rsp_valid && !rsp_access_source, !rsp_access_kind)
   // The normal and multiplexed latch layouts never mix in one access.
   `ASSERT_IMPLIES(a_layout_exclusive, clock, reset, rsp_valid && (rsp_latch_high != 8'h00), (rsp_column_low == 8'h00) && (rsp_column_high == 8'h00))
   // A table access that is not the last is followed by another access of the same item.
   `ASSERT_NEXT(a_replay_continues, clock, reset, rsp_valid && !rsp_stall && !rsp_last, rsp_valid)

endmodule

// ===== rtl/core/fwseq_front.sv =====
// Front end of the flash write sequencer: accepts request transactions and classifies them.
// Depends on fwseq_pkg.
module fwseq_front (
   input  logic                    req_valid,
   input  logic [2:0]              req_func,
   input  logic [23:0]             req_cmd_address,
   input  logic [7:0]              req_cmd_data,
   input  logic [31:0]             req_start_address,
   input  logic [15:0]             req_write_length,
   input  logic [7:0]              req_data_byte,
   output logic                    req_stall,
   input  fwseq_pkg::q_status_type q_status,
   output logic                    q_push,
   output fwseq_pkg::entry_type    q_entry
);

   logic known_func;

   always_comb begin
      known_func = 1'b1;
      q_entry.op = fwseq_pkg::OP_HOLD;
      unique case (req_func)
         fwseq_pkg::FUNC_HOLD:        q_entry.op = fwseq_pkg::OP_HOLD;
         fwseq_pkg::FUNC_RUN:         q_entry.op = fwseq_pkg::OP_RUN;
         fwseq_pkg::FUNC_INIT:        q_entry.op = fwseq_pkg::OP_INIT;
         fwseq_pkg::FUNC_START_READ:  q_entry.op = fwseq_pkg::OP_START_READ;
         fwseq_pkg::FUNC_START_WRITE: q_entry.op = fwseq_pkg::OP_START_WRITE;
         fwseq_pkg::FUNC_READ_BYTE:   q_entry.op = fwseq_pkg::OP_READ_BYTE;
         fwseq_pkg::FUNC_WRITE_BYTE:  q_entry.op = fwseq_pkg::OP_WRITE_BYTE;
         default:                     known_func = 1'b0;
      endcase
      q_entry.cmd_address   = req_cmd_address;
      q_entry.cmd_data      = req_cmd_data;
      q_entry.start_address = req_start_address;
      q_entry.write_length  = req_write_length;
      q_entry.data_byte     = req_data_byte;
   end

   // The unused function code has no effect at all, so it is taken and dropped.
   assign req_stall = q_status.full;
   assign q_push    = req_valid && !q_status.full && known_func;

endmodule

// ===== rtl/core/fwseq_queue.sv =====
// Short queue between the front and back ends of the flash write sequencer.
// Depends on fwseq_pkg.
module fwseq_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  fwseq_pkg::entry_type    push_entry,
   input  logic                    pop,
   output fwseq_pkg::entry_type    head_entry,
   output fwseq_pkg::q_status_type status
);

   localparam int DEPTH = fwseq_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   fwseq_pkg::entry_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      ptr_next = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head_entry       = slot_ff[rd_ptr_ff];
   assign status.not_empty = (count_ff != '0);
   assign status.full      = (count_ff == CNT_W'(DEPTH));

endmodule

// ===== rtl/core/fwseq_back.sv =====
// Back end of the flash write sequencer: command table, flash address state and access output.
// Depends on fwseq_pkg.
module fwseq_back #(
   parameter int COMMAND_SLOTS = fwseq_pkg::DEF_COMMAND_SLOTS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  fwseq_pkg::q_status_type             q_status,
   input  fwseq_pkg::entry_type                q_entry,
   output logic                                q_pop,
   input  logic                                csr_valid,
   input  logic [fwseq_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [31:0]                         csr_data,
   input  logic                                rsp_stall,
   output logic                                rsp_valid,
   output logic                                rsp_access_kind,
   output logic                                rsp_access_source,
   output logic [31:0]                         rsp_flash_address,
   output logic [7:0]                          rsp_write_value,
   output logic [7:0]                          rsp_latch_low,
   output logic [7:0]                          rsp_latch_mid,
   output logic [7:0]                          rsp_latch_high,
   output logic [7:0]                          rsp_column_low,
   output logic [7:0]                          rsp_column_high,
   output logic                                rsp_last
);

   localparam int IDX_W = (COMMAND_SLOTS > 1) ? $clog2(COMMAND_SLOTS) : 1;
   localparam int CNT_W = $clog2(COMMAND_SLOTS + 1);

   fwseq_pkg::back_state_type state_ff, state_in;
   fwseq_pkg::mode_type       mode_ff;

   logic [31:0]      table_ff [COMMAND_SLOTS];
   logic [31:0]      rdata_ff;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] count_ff;
   logic [31:0]      address_ff;
   logic [31:0]      countdown_ff;
   logic [15:0]      remaining_ff;
   logic [31:0]      block_size_ff;
   logic             mux_mode_ff;
   logic             is_write_ff;
   logic             then_data_ff;
   logic [7:0]       data_byte_ff;

   logic             rsp_valid_ff;
   logic             rsp_kind_ff;
   logic             rsp_source_ff;
   logic [31:0]      rsp_address_ff;
   logic [7:0]       rsp_value_ff;
   logic             rsp_mux_ff;
   logic             rsp_last_ff;

   logic             slot_free;
   logic             emit;
   logic             need_replay;
   logic             write_ok;
   logic             rep_last;
   logic [31:0]      rep_address;
   logic             out_kind;
   logic             out_source;
   logic [31:0]      out_address;
   logic [7:0]       out_value;
   logic             out_last;
   logic [IDX_W-1:0] hold_slot;

   assign write_ok    = (mode_ff == fwseq_pkg::MODE_WRITE) && (remaining_ff != '0);
   assign need_replay = (countdown_ff == '0) && (count_ff != '0);
   assign rep_last    = ({{(CNT_W - IDX_W){1'b0}}, idx_ff} + CNT_W'(1)) == count_ff;
   assign rep_address = (rdata_ff[31:8] == fwseq_pkg::ADDR_ALL_ONES)
                        ? address_ff : {8'h00, rdata_ff[31:8]};
   assign hold_slot   = (count_ff >= CNT_W'(COMMAND_SLOTS)) ? '0 : count_ff[IDX_W-1:0];
   assign slot_free   = !rsp_valid_ff || !rsp_stall;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fwseq_pkg::B_IDLE: begin
            if (q_status.not_empty) begin
               case (q_entry.op)
                  fwseq_pkg::OP_RUN: begin
                     if (count_ff != '0) begin
                        state_in = fwseq_pkg::B_REPLAY;
                     end
                  end
                  fwseq_pkg::OP_READ_BYTE: begin
                     if (mode_ff == fwseq_pkg::MODE_READ) begin
                        state_in = fwseq_pkg::B_DATA;
                     end
                  end
                  fwseq_pkg::OP_WRITE_BYTE: begin
                     if (write_ok) begin
                        state_in = need_replay ? fwseq_pkg::B_REPLAY : fwseq_pkg::B_DATA;
                     end
                  end
                  default: state_in = fwseq_pkg::B_IDLE;
               endcase
            end
         end
         fwseq_pkg::B_REPLAY: begin
            if (slot_free && rep_last) begin
               state_in = then_data_ff ? fwseq_pkg::B_DATA : fwseq_pkg::B_IDLE;
            end
         end
         fwseq_pkg::B_DATA: begin
            if (slot_free) begin
               state_in = fwseq_pkg::B_IDLE;
            end
         end
         default: state_in = fwseq_pkg::B_IDLE;
      endcase
   end

   // Outputs of the sequencer: queue pop, access emission and table read index.
   always_comb begin
      q_pop       = 1'b0;
      emit        = 1'b0;
      idx_in      = idx_ff;
      out_kind    = fwseq_pkg::ACCESS_WRITE;
      out_source  = fwseq_pkg::SOURCE_DATA;
      out_address = address_ff;
      out_value   = data_byte_ff;
      out_last    = 1'b1;
      unique case (state_ff)
         fwseq_pkg::B_IDLE: begin
            q_pop  = q_status.not_empty;
            idx_in = '0;
         end
         fwseq_pkg::B_REPLAY: begin
            emit        = slot_free;
            out_source  = fwseq_pkg::SOURCE_TABLE;
            out_address = rep_address;
            out_value   = rdata_ff[7:0];
            out_last    = rep_last && !then_data_ff;
            if (slot_free) begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         fwseq_pkg::B_DATA: begin
            emit = slot_free;
            if (!is_write_ff) begin
               out_kind  = fwseq_pkg::ACCESS_READ;
               out_value = 8'h00;
            end
         end
         default: begin
            q_pop = 1'b0;
         end
      endcase
   end

   // Command table with a registered read port.
   always_ff @(posedge clock) begin
      if (q_pop && (q_entry.op == fwseq_pkg::OP_HOLD)) begin
         table_ff[hold_slot] <= {q_entry.cmd_address, q_entry.cmd_data};
      end
      rdata_ff <= table_ff[idx_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= fwseq_pkg::B_IDLE;
         mode_ff       <= fwseq_pkg::MODE_IDLE;
         idx_ff        <= '0;
         count_ff      <= '0;
         address_ff    <= '0;
         countdown_ff  <= '0;
         remaining_ff  <= '0;
         block_size_ff <= '0;
         mux_mode_ff   <= 1'b0;
         is_write_ff   <= 1'b0;
         then_data_ff  <= 1'b0;
         data_byte_ff  <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         if (csr_valid) begin
            if (csr_index == fwseq_pkg::CSR_BLOCK_SIZE) begin
               block_size_ff <= csr_data;
            end else if (csr_index == fwseq_pkg::CSR_MUX_MODE) begin
               mux_mode_ff <= csr_data[0];
            end
         end
         if (q_pop) begin
            case (q_entry.op)
               fwseq_pkg::OP_HOLD: begin
                  mode_ff  <= fwseq_pkg::MODE_IDLE;
                  count_ff <= {{(CNT_W - IDX_W){1'b0}}, hold_slot} + CNT_W'(1);
               end
               fwseq_pkg::OP_RUN: begin
                  mode_ff      <= fwseq_pkg::MODE_IDLE;
                  then_data_ff <= 1'b0;
               end
               fwseq_pkg::OP_INIT: begin
                  mode_ff       <= fwseq_pkg::MODE_IDLE;
                  mux_mode_ff   <= 1'b0;
                  block_size_ff <= '0;
                  countdown_ff  <= '0;
                  count_ff      <= '0;
               end
               fwseq_pkg::OP_START_READ: begin
                  mode_ff    <= fwseq_pkg::MODE_READ;
                  address_ff <= q_entry.start_address;
               end
               fwseq_pkg::OP_START_WRITE: begin
                  mode_ff      <= fwseq_pkg::MODE_WRITE;
                  address_ff   <= q_entry.start_address;
                  remaining_ff <= q_entry.write_length;
               end
               fwseq_pkg::OP_READ_BYTE: begin
                  is_write_ff <= 1'b0;
               end
               fwseq_pkg::OP_WRITE_BYTE: begin
                  is_write_ff  <= 1'b1;
                  then_data_ff <= 1'b1;
                  data_byte_ff <= q_entry.data_byte;
                  if (write_ok && need_replay) begin
                     countdown_ff <= block_size_ff;
                  end
               end
               default: begin
                  is_write_ff <= is_write_ff;
               end
            endcase
         end
         // The data access itself moves the address and the write counters.
         if ((state_ff == fwseq_pkg::B_DATA) && slot_free) begin
            address_ff <= address_ff + 32'd1;
            if (is_write_ff) begin
               remaining_ff <= remaining_ff - 16'd1;
               if (countdown_ff != '0) begin
                  countdown_ff <= countdown_ff - 32'd1;
               end
            end
         end
      end
   end

   // Output register parts the back end from the receiver.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_kind_ff    <= out_kind;
         rsp_source_ff  <= out_source;
         rsp_address_ff <= out_address;
         rsp_value_ff   <= out_value;
         rsp_mux_ff     <= mux_mode_ff;
         rsp_last_ff    <= out_last;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_access_kind   = rsp_kind_ff;
   assign rsp_access_source = rsp_source_ff;
   assign rsp_flash_address = rsp_address_ff;
   assign rsp_write_value   = rsp_value_ff;
   assign rsp_latch_low     = rsp_address_ff[7:0];
   assign rsp_latch_mid     = rsp_address_ff[15:8];
   assign rsp_latch_high    = rsp_mux_ff ? 8'h00 : rsp_address_ff[23:16];
   assign rsp_column_low    = rsp_mux_ff ? rsp_address_ff[18:11] : 8'h00;
   assign rsp_column_high   = rsp_mux_ff ? rsp_address_ff[26:19] : 8'h00;
   assign rsp_last          = rsp_last_ff;

endmodule
